// ===== rtl/vfa_pkg.sv =====
// ----------------------------------------------------------------------------
// vfa_pkg
// shared types, codes and arithmetic helpers of the Q16.16 vector alu
// ----------------------------------------------------------------------------
`default_nettype none

package vfa_pkg;

  // operation codes
  localparam logic [3:0] CMD_ADD   = 4'd0;
  localparam logic [3:0] CMD_SUB   = 4'd1;
  localparam logic [3:0] CMD_SCALE = 4'd2;
  localparam logic [3:0] CMD_DIV   = 4'd3;
  localparam logic [3:0] CMD_DOT   = 4'd4;
  localparam logic [3:0] CMD_CROSS = 4'd5;
  localparam logic [3:0] CMD_NEG   = 4'd6;
  localparam logic [3:0] CMD_MAG   = 4'd7;
  localparam logic [3:0] CMD_NORM  = 4'd8;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // pipeline depths of the root and divide units
  localparam int SQ_STAGES  = 32;
  localparam int DIV_STAGES = 48;

  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;
  localparam logic [31:0] MAX32 = 32'h7fffffff;
  localparam logic [31:0] MIN32 = 32'h80000000;

  // item state carried alongside the root and divide units
  typedef struct packed {
    logic [3:0]  cmd;
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
    logic [31:0] sc;
    logic [31:0] s;
    logic [1:0]  status;
  } pl_t;

  typedef struct packed {
    logic [31:0] v;
    logic        sat;
  } sat_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sq_step_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [47:0] qd;
  } dv_step_t;

  // clamp to the signed 32-bit range
  function automatic sat_t sat66(input logic signed [65:0] x);
    sat_t o;
    if (x > SAT_HI) begin
      o.v = MAX32;
      o.sat = 1'b1;
    end else if (x < SAT_LO) begin
      o.v = MIN32;
      o.sat = 1'b1;
    end else begin
      o.v = x[31:0];
      o.sat = 1'b0;
    end
    return o;
  endfunction

  // Q32.32 to Q16.16, add one half then floor
  function automatic logic signed [65:0] rnd16(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = x + 66'sd32768;
    return t >>> 16;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? 32'd0 - x : x;
  endfunction

  // one digit of the bitwise integer square root, k is the digit place
  function automatic sq_step_t sq_step(input logic [63:0] n, input logic [63:0] r,
                                       input int k);
    sq_step_t o;
    logic [63:0] b;
    logic [64:0] t;
    b = 64'd1 << (2 * k);
    t = {1'b0, r} + {1'b0, b};
    if ({1'b0, n} >= t) begin
      o.n = n - t[63:0];
      o.r = (r >> 1) + b;
    end else begin
      o.n = n;
      o.r = r >> 1;
    end
    return o;
  endfunction

  // one quotient bit of restoring division, dividend shifts out as quotient shifts in
  function automatic dv_step_t dv_step(input logic [31:0] rem, input logic [47:0] qd,
                                       input logic [31:0] dv);
    dv_step_t o;
    logic [32:0] sh;
    logic [32:0] diff;
    sh = {rem, qd[47]};
    diff = sh - {1'b0, dv};
    if (sh >= {1'b0, dv}) begin
      o.rem = diff[31:0];
      o.qd = {qd[46:0], 1'b1};
    end else begin
      o.rem = sh[31:0];
      o.qd = {qd[46:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vfa_in_if.sv =====
// ----------------------------------------------------------------------------
// vfa_in_if
// operation channel of the vector alu: code, vectors a and b, scalar
// ----------------------------------------------------------------------------
`default_nettype none

interface vfa_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        cmd;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scalar_in;

  modport source (output valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  input ready);
  modport sink (input valid, cmd, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/vfa_out_if.sv =====
// ----------------------------------------------------------------------------
// vfa_out_if
// result channel of the vector alu: vector, scalar and status
// ----------------------------------------------------------------------------
`default_nettype none

interface vfa_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] scalar_out;
  logic [1:0]        status;

  modport source (output valid, r_x, r_y, r_z, scalar_out, status, input ready);
  modport sink (input valid, r_x, r_y, r_z, scalar_out, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/vfa_isqrt.sv =====
// ----------------------------------------------------------------------------
// vfa_isqrt
// pipelined 64-bit integer square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  output logic [31:0] root
);

  logic [63:0] n_q [vfa_pkg::SQ_STAGES-1];
  logic [63:0] r_q [vfa_pkg::SQ_STAGES];
  vfa_pkg::sq_step_t nx [vfa_pkg::SQ_STAGES];

  always_comb begin
    nx[0] = vfa_pkg::sq_step(n, 64'd0, vfa_pkg::SQ_STAGES - 1);
    for (int i = 1; i < vfa_pkg::SQ_STAGES; i++) begin
      nx[i] = vfa_pkg::sq_step(n_q[i-1], r_q[i-1], vfa_pkg::SQ_STAGES - 1 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < vfa_pkg::SQ_STAGES - 1; i++) begin
        n_q[i] <= nx[i].n;
      end
      for (int i = 0; i < vfa_pkg::SQ_STAGES; i++) begin
        r_q[i] <= nx[i].r;
      end
    end
  end

  // final root is below 2^32
  assign root = r_q[vfa_pkg::SQ_STAGES-1][31:0];

endmodule

`default_nettype wire

// ===== rtl/vfa_div.sv =====
// ----------------------------------------------------------------------------
// vfa_div
// pipelined unsigned 48 by 32 bit divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_div (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic [47:0] quotient
);

  logic [31:0] rem_q [vfa_pkg::DIV_STAGES-1];
  logic [47:0] qd_q  [vfa_pkg::DIV_STAGES];
  logic [31:0] dv_q  [vfa_pkg::DIV_STAGES-1];
  vfa_pkg::dv_step_t nx [vfa_pkg::DIV_STAGES];

  always_comb begin
    nx[0] = vfa_pkg::dv_step(32'd0, dividend, divisor);
    for (int i = 1; i < vfa_pkg::DIV_STAGES; i++) begin
      nx[i] = vfa_pkg::dv_step(rem_q[i-1], qd_q[i-1], dv_q[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_q[0] <= divisor;
      for (int i = 1; i < vfa_pkg::DIV_STAGES - 1; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
      for (int i = 0; i < vfa_pkg::DIV_STAGES - 1; i++) begin
        rem_q[i] <= nx[i].rem;
      end
      for (int i = 0; i < vfa_pkg::DIV_STAGES; i++) begin
        qd_q[i] <= nx[i].qd;
      end
    end
  end

  assign quotient = qd_q[vfa_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/vector3_fixed_point_alu.sv =====
// every operation runs through all stages, root and divider included, on its way to the result
// throughput: one item per cycle while not stalled; the 32-stage root and the 48-stage divider are fully
//   pipelined, so square root and divide do not hold back the next item
// stalls: the whole pipeline freezes while a result waits and the sink is not ready
// reset: synchronous, active high; clears all valid bits, data registers are not reset
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// three-component Q16.16 vector alu: add, sub, scale, divide, dot, cross,
// negate, magnitude and normalize with saturation and status
// ----------------------------------------------------------------------------
`default_nettype none

module vector3_fixed_point_alu (
  input  logic      clk,
  input  logic      rst,
  vfa_in_if.sink    din,
  vfa_out_if.source dout
);

  // pipeline enable: advance unless a finished result is held back
  logic en;
  logic out_valid;

  assign en        = !out_valid || dout.ready;
  assign din.ready = en;

  // --------------------------------------------------------------------------
  // stage 1: operand select and the six multipliers
  // --------------------------------------------------------------------------
  logic signed [31:0] ia [3];
  logic signed [31:0] ib [3];
  logic signed [31:0] ma [6];
  logic signed [31:0] mb [6];

  assign ia[0] = din.a_x;
  assign ia[1] = din.a_y;
  assign ia[2] = din.a_z;
  assign ib[0] = din.b_x;
  assign ib[1] = din.b_y;
  assign ib[2] = din.b_z;

  always_comb begin
    // default: squares of a for magnitude and normalize
    for (int i = 0; i < 3; i++) begin
      ma[i]   = ia[i];
      mb[i]   = ia[i];
      ma[i+3] = 32'sd0;
      mb[i+3] = 32'sd0;
    end
    case (din.cmd)
      vfa_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) mb[i] = din.scalar_in;
      end
      vfa_pkg::CMD_DOT: begin
        for (int i = 0; i < 3; i++) mb[i] = ib[i];
      end
      vfa_pkg::CMD_CROSS: begin
        // x = ay*bz - by*az, y = az*bx - bz*ax, z = ax*by - bx*ay
        ma[0] = ia[1]; mb[0] = ib[2]; ma[3] = ib[1]; mb[3] = ia[2];
        ma[1] = ia[2]; mb[1] = ib[0]; ma[4] = ib[2]; mb[4] = ia[0];
        ma[2] = ia[0]; mb[2] = ib[1]; ma[5] = ib[0]; mb[5] = ia[1];
      end
      default: begin
      end
    endcase
  end

  logic               v1;
  logic [3:0]         cmd1;
  logic signed [31:0] a1 [3];
  logic signed [31:0] b1 [3];
  logic signed [31:0] s1;
  logic signed [63:0] p1 [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= din.cmd;
      s1   <= din.scalar_in;
      for (int i = 0; i < 3; i++) begin
        a1[i] <= ia[i];
        b1[i] <= ib[i];
      end
      for (int i = 0; i < 6; i++) begin
        p1[i] <= ma[i] * mb[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: exact sums, rounding to Q16.16, add/sub/negate, sum of squares
  // --------------------------------------------------------------------------
  logic signed [65:0] w [6];
  logic signed [65:0] vr2n [3];
  logic signed [65:0] d2n;
  logic [63:0]        ss2n;

  always_comb begin
    for (int i = 0; i < 6; i++) w[i] = 66'(p1[i]);
    for (int i = 0; i < 3; i++) vr2n[i] = 66'sd0;
    d2n  = 66'sd0;
    ss2n = $unsigned(p1[0]) + $unsigned(p1[1]) + $unsigned(p1[2]);
    case (cmd1)
      vfa_pkg::CMD_ADD: begin
        for (int i = 0; i < 3; i++) vr2n[i] = 66'(a1[i]) + 66'(b1[i]);
      end
      vfa_pkg::CMD_SUB: begin
        for (int i = 0; i < 3; i++) vr2n[i] = 66'(a1[i]) - 66'(b1[i]);
      end
      vfa_pkg::CMD_NEG: begin
        for (int i = 0; i < 3; i++) vr2n[i] = 66'sd0 - 66'(a1[i]);
      end
      vfa_pkg::CMD_SCALE: begin
        for (int i = 0; i < 3; i++) vr2n[i] = vfa_pkg::rnd16(w[i]);
      end
      vfa_pkg::CMD_CROSS: begin
        for (int i = 0; i < 3; i++) vr2n[i] = vfa_pkg::rnd16(w[i] - w[i+3]);
      end
      vfa_pkg::CMD_DOT: begin
        d2n = vfa_pkg::rnd16(w[0] + w[1] + w[2]);
      end
      default: begin
      end
    endcase
  end

  logic               v2;
  logic [3:0]         cmd2;
  logic signed [31:0] a2 [3];
  logic signed [31:0] s2;
  logic signed [65:0] vr2 [3];
  logic signed [65:0] d2;
  logic [63:0]        ss2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd2 <= cmd1;
      s2   <= s1;
      d2   <= d2n;
      ss2  <= ss2n;
      for (int i = 0; i < 3; i++) begin
        a2[i]  <= a1[i];
        vr2[i] <= vr2n[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: saturation; divide and normalize park vector a in the result
  // fields so it rides along to the divider and covers the zero cases
  // --------------------------------------------------------------------------
  vfa_pkg::sat_t sx [3];
  vfa_pkg::sat_t sd;
  vfa_pkg::pl_t  pl3n;

  always_comb begin
    for (int i = 0; i < 3; i++) sx[i] = vfa_pkg::sat66(vr2[i]);
    sd = vfa_pkg::sat66(d2);
    pl3n        = '0;
    pl3n.cmd    = cmd2;
    pl3n.s      = s2;
    pl3n.status = vfa_pkg::ST_OK;
    case (cmd2) inside
      vfa_pkg::CMD_ADD, vfa_pkg::CMD_SUB, vfa_pkg::CMD_SCALE,
      vfa_pkg::CMD_CROSS, vfa_pkg::CMD_NEG: begin
        pl3n.r_x = sx[0].v;
        pl3n.r_y = sx[1].v;
        pl3n.r_z = sx[2].v;
        if (sx[0].sat || sx[1].sat || sx[2].sat) pl3n.status = vfa_pkg::ST_SAT;
      end
      vfa_pkg::CMD_DOT: begin
        pl3n.sc = sd.v;
        if (sd.sat) pl3n.status = vfa_pkg::ST_SAT;
      end
      vfa_pkg::CMD_DIV, vfa_pkg::CMD_NORM: begin
        pl3n.r_x = a2[0];
        pl3n.r_y = a2[1];
        pl3n.r_z = a2[2];
      end
      default: begin
      end
    endcase
  end

  logic         v3;
  vfa_pkg::pl_t pl3;
  logic [63:0]  ss3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl3 <= pl3n;
      ss3 <= ss2;
    end
  end

  // --------------------------------------------------------------------------
  // square root unit with the item state riding beside it
  // --------------------------------------------------------------------------
  logic [31:0]  root;
  logic         vq [vfa_pkg::SQ_STAGES];
  vfa_pkg::pl_t pq [vfa_pkg::SQ_STAGES];

  vfa_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .n    (ss3),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vfa_pkg::SQ_STAGES; i++) vq[i] <= 1'b0;
    end else if (en) begin
      vq[0] <= v3;
      for (int i = 1; i < vfa_pkg::SQ_STAGES; i++) vq[i] <= vq[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pq[0] <= pl3;
      for (int i = 1; i < vfa_pkg::SQ_STAGES; i++) pq[i] <= pq[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: magnitude result, zero checks, divider operands
  // --------------------------------------------------------------------------
  vfa_pkg::pl_t pl4n;
  logic [31:0]  dvs4n;
  logic [47:0]  dvd4n [3];

  always_comb begin
    pl4n  = pq[vfa_pkg::SQ_STAGES-1];
    dvs4n = root;
    dvd4n[0] = {vfa_pkg::mag32(pl4n.r_x), 16'd0};
    dvd4n[1] = {vfa_pkg::mag32(pl4n.r_y), 16'd0};
    dvd4n[2] = {vfa_pkg::mag32(pl4n.r_z), 16'd0};
    case (pl4n.cmd)
      vfa_pkg::CMD_MAG: begin
        if (root > vfa_pkg::MAX32) begin
          pl4n.sc     = vfa_pkg::MAX32;
          pl4n.status = vfa_pkg::ST_SAT;
        end else begin
          pl4n.sc = root;
        end
      end
      vfa_pkg::CMD_NORM: begin
        // zero length: a passes through unchanged
        if (root == 32'd0) pl4n.status = vfa_pkg::ST_ZERO;
      end
      vfa_pkg::CMD_DIV: begin
        dvs4n = vfa_pkg::mag32(pl4n.s);
        if (pl4n.s == 32'd0) pl4n.status = vfa_pkg::ST_ZERO;
      end
      default: begin
      end
    endcase
  end

  logic         v4;
  vfa_pkg::pl_t pl4;
  logic [31:0]  dvs4;
  logic [47:0]  dvd4 [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vq[vfa_pkg::SQ_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl4  <= pl4n;
      dvs4 <= dvs4n;
      for (int i = 0; i < 3; i++) dvd4[i] <= dvd4n[i];
    end
  end

  // --------------------------------------------------------------------------
  // three divider lanes, magnitudes only; signs are applied afterwards
  // --------------------------------------------------------------------------
  logic [47:0]  quo [3];
  logic         vd [vfa_pkg::DIV_STAGES];
  vfa_pkg::pl_t pd [vfa_pkg::DIV_STAGES];

  for (genvar g = 0; g < 3; g++) begin : g_div
    vfa_div u_div (
      .clk      (clk),
      .en       (en),
      .dividend (dvd4[g]),
      .divisor  (dvs4),
      .quotient (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vfa_pkg::DIV_STAGES; i++) vd[i] <= 1'b0;
    end else if (en) begin
      vd[0] <= v4;
      for (int i = 1; i < vfa_pkg::DIV_STAGES; i++) vd[i] <= vd[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd[0] <= pl4;
      for (int i = 1; i < vfa_pkg::DIV_STAGES; i++) pd[i] <= pd[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // final stage: signed quotients, saturation, divide-by-zero clamp
  // --------------------------------------------------------------------------
  vfa_pkg::pl_t       plf;
  logic [31:0]        fa [3];
  logic [31:0]        fr [3];
  logic signed [65:0] qv [3];
  logic               neg [3];
  vfa_pkg::sat_t      fs [3];
  logic [1:0]         fst;

  always_comb begin
    plf   = pd[vfa_pkg::DIV_STAGES-1];
    fa[0] = plf.r_x;
    fa[1] = plf.r_y;
    fa[2] = plf.r_z;
    fst   = plf.status;
    for (int i = 0; i < 3; i++) begin
      fr[i]  = fa[i];
      neg[i] = (plf.cmd == vfa_pkg::CMD_DIV) ? (fa[i][31] ^ plf.s[31]) : fa[i][31];
      qv[i]  = $signed({18'd0, quo[i]});
      fs[i]  = vfa_pkg::sat66(neg[i] ? 66'sd0 - qv[i] : qv[i]);
    end
    if ((plf.cmd == vfa_pkg::CMD_DIV || plf.cmd == vfa_pkg::CMD_NORM) &&
        plf.status != vfa_pkg::ST_ZERO) begin
      for (int i = 0; i < 3; i++) fr[i] = fs[i].v;
      if (fs[0].sat || fs[1].sat || fs[2].sat) fst = vfa_pkg::ST_SAT;
    end else if (plf.cmd == vfa_pkg::CMD_DIV) begin
      // divide by zero: clamp toward the sign of each component
      for (int i = 0; i < 3; i++) begin
        if (fa[i] == 32'd0) fr[i] = 32'd0;
        else if (fa[i][31]) fr[i] = vfa_pkg::MIN32;
        else fr[i] = vfa_pkg::MAX32;
      end
    end
  end

  // output register
  logic [31:0] res_x;
  logic [31:0] res_y;
  logic [31:0] res_z;
  logic [31:0] res_sc;
  logic [1:0]  res_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd[vfa_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x  <= fr[0];
      res_y  <= fr[1];
      res_z  <= fr[2];
      res_sc <= plf.sc;
      res_st <= fst;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.r_x        = res_x;
  assign dout.r_y        = res_y;
  assign dout.r_z        = res_z;
  assign dout.scalar_out = res_sc;
  assign dout.status     = res_st;

endmodule

`default_nettype wire

// ===== rtl/vfa_chk.sv =====
// ----------------------------------------------------------------------------
// vfa_chk
// port-level checks of the vector alu, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module vfa_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] r_x,
  input logic [31:0] r_y,
  input logic [31:0] r_z,
  input logic [31:0] scalar_out,
  input logic [1:0]  status
);

  // a held result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a held result keeps its value
  a_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(r_x) && $stable(r_y) && $stable(r_z) &&
                                $stable(scalar_out) && $stable(status))
    else $error("result changed while stalled");

  // the pipeline only stalls on back pressure
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // zero divisor and zero length are vector operations, scalar stays clear
  a_zero_sc: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == vfa_pkg::ST_ZERO |-> scalar_out == 32'd0)
    else $error("scalar set with zero status");

endmodule

bind vector3_fixed_point_alu vfa_chk u_vfa_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .r_x        (dout.r_x),
  .r_y        (dout.r_y),
  .r_z        (dout.r_z),
  .scalar_out (dout.scalar_out),
  .status     (dout.status)
);

`default_nettype wire

// ===== tb/tb_vector3_fixed_point_alu.sv =====
// ----------------------------------------------------------------------------
// tb_vector3_fixed_point_alu
// self-checking bench for the Q16.16 vector alu: directed corner items, then
// random items under three idling phases, each result checked against a
// local predictor of the fixed-point arithmetic
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vector3_fixed_point_alu;

  typedef struct {
    logic [3:0]         cmd;
    logic signed [31:0] ax, ay, az, bx, by, bz, s;
  } op_t;

  typedef struct {
    logic signed [31:0] rx, ry, rz, sc;
    logic [1:0]         st;
  } res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vfa_in_if  din ();
  vfa_out_if dout ();

  vector3_fixed_point_alu dut (.clk(clk), .rst(rst), .din(din), .dout(dout));

  always #1 clk = ~clk;

  op_t  pending_ops[$];
  res_t expected_results[$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   hold_send = 1'b0;
  bit   failed = 1'b0;
  int   cycles = 0;

  // clamp a wide value into int32, flag when clipped
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Q32.32 to Q16.16: add one half, floor
  function automatic logic signed [127:0] round_q(input logic signed [127:0] v);
    return (v + 128'sd32768) >>> 16;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] n);
    logic [127:0] r, b;
    r = 0;
    b = 128'd1 << 126;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  // truncating signed divide of a scaled by 2^16
  function automatic logic signed [127:0] div_q(input logic signed [127:0] a,
                                                input logic signed [127:0] d);
    logic signed [127:0] n;
    n = a * 128'sd65536;
    return n / d;
  endfunction

  function automatic res_t predict_alu(input op_t o);
    res_t r;
    logic signed [127:0] a[3], b[3], v[3], s;
    logic [127:0] sq;
    logic [63:0]  m;
    bit sat, zero, vec;
    sat = 0;
    zero = 0;
    vec = 1;
    a[0] = o.ax; a[1] = o.ay; a[2] = o.az;
    b[0] = o.bx; b[1] = o.by; b[2] = o.bz;
    s = o.s;
    for (int i = 0; i < 3; i++) v[i] = 0;
    r.sc = 0;
    sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    case (o.cmd)
      vfa_pkg::CMD_ADD:   for (int i = 0; i < 3; i++) v[i] = a[i] + b[i];
      vfa_pkg::CMD_SUB:   for (int i = 0; i < 3; i++) v[i] = a[i] - b[i];
      vfa_pkg::CMD_SCALE: for (int i = 0; i < 3; i++) v[i] = round_q(a[i] * s);
      vfa_pkg::CMD_DIV: begin
        zero = (s == 0);
        for (int i = 0; i < 3; i++)
          if (zero) v[i] = a[i] > 0 ? 128'sd2147483647 : (a[i] < 0 ? -128'sd2147483648 : 0);
          else v[i] = div_q(a[i], s);
      end
      vfa_pkg::CMD_DOT: begin
        r.sc = clamp32(round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), sat);
        vec = 0;
      end
      vfa_pkg::CMD_CROSS: begin
        v[0] = round_q(a[1] * b[2] - b[1] * a[2]);
        v[1] = round_q(a[2] * b[0] - b[2] * a[0]);
        v[2] = round_q(a[0] * b[1] - b[0] * a[1]);
      end
      vfa_pkg::CMD_NEG: for (int i = 0; i < 3; i++) v[i] = -a[i];
      vfa_pkg::CMD_MAG: begin
        m = int_sqrt(sq);
        r.sc = clamp32($signed({64'd0, m}), sat);
        vec = 0;
      end
      vfa_pkg::CMD_NORM: begin
        m = int_sqrt(sq);
        if (m == 0) begin
          zero = 1;
          for (int i = 0; i < 3; i++) v[i] = a[i];
        end else begin
          for (int i = 0; i < 3; i++) v[i] = div_q(a[i], $signed({64'd0, m}));
        end
      end
      default: vec = 0;
    endcase
    r.rx = vec ? clamp32(v[0], sat) : 0;
    r.ry = vec ? clamp32(v[1], sat) : 0;
    r.rz = vec ? clamp32(v[2], sat) : 0;
    r.st = zero ? vfa_pkg::ST_ZERO : (sat ? vfa_pkg::ST_SAT : vfa_pkg::ST_OK);
    return r;
  endfunction

  // operand mix: extremes, small q16.16 values, full random
  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3, 4: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      5: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic op_t rand_op();
    op_t o;
    o.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
    o.ax = rand_word(); o.ay = rand_word(); o.az = rand_word();
    o.bx = rand_word(); o.by = rand_word(); o.bz = rand_word();
    // divisor and length zero show up often enough to matter
    o.s = ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_word();
    if ($urandom_range(0, 19) == 0) begin
      o.ax = 0; o.ay = 0; o.az = 0;
    end
    return o;
  endfunction

  function automatic op_t mk_op(input logic [3:0] c, input logic signed [31:0] ax,
                                input logic signed [31:0] ay, input logic signed [31:0] az,
                                input logic signed [31:0] bx, input logic signed [31:0] by,
                                input logic signed [31:0] bz, input logic signed [31:0] s);
    op_t o;
    o.cmd = c; o.ax = ax; o.ay = ay; o.az = az;
    o.bx = bx; o.by = by; o.bz = bz; o.s = s;
    return o;
  endfunction

  // driver: one transfer per handshake, random gaps on valid
  always @(posedge clk) begin
    if (rst) begin
      din.valid <= 1'b0;
    end else begin
      // the offered item stays at the head of the queue until it moves
      if (din.valid && din.ready) begin
        expected_results.push_back(predict_alu(pending_ops.pop_front()));
      end
      if (!din.valid || din.ready) begin
        if (pending_ops.size() > 0 && !hold_send
            && $urandom_range(0, 99) >= send_idle_pct) begin
          op_t o;
          o = pending_ops[0];
          din.valid     <= 1'b1;
          din.cmd       <= o.cmd;
          din.a_x       <= o.ax;
          din.a_y       <= o.ay;
          din.a_z       <= o.az;
          din.b_x       <= o.bx;
          din.b_y       <= o.by;
          din.b_z       <= o.bz;
          din.scalar_in <= o.s;
        end else begin
          din.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    dout.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
    if (!rst && dout.valid && dout.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result expected none actual %h %h %h %h %0d", $time,
                 dout.r_x, dout.r_y, dout.r_z, dout.scalar_out, dout.status);
        failed = 1'b1;
      end else begin
        e = expected_results.pop_front();
        if (dout.r_x !== e.rx || dout.r_y !== e.ry || dout.r_z !== e.rz ||
            dout.scalar_out !== e.sc || dout.status !== e.st) begin
          $display("%0t mismatch expected %h %h %h %h %0d actual %h %h %h %h %0d",
                   $time, e.rx, e.ry, e.rz, e.sc, e.st,
                   dout.r_x, dout.r_y, dout.r_z, dout.scalar_out, dout.status);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    din.valid = 1'b0;
    din.cmd = 0;
    din.a_x = 0; din.a_y = 0; din.a_z = 0;
    din.b_x = 0; din.b_y = 0; din.b_z = 0;
    din.scalar_in = 0;
    dout.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: each operation, extremes, division by zero, zero length
    pending_ops.push_back(mk_op(vfa_pkg::CMD_ADD, 32'sh7fffffff, 32'sh80000000, 1,
                                1, -1, 2, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_SUB, 32'sh80000000, 32'sh7fffffff, 5,
                                1, -1, 5, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_SCALE, 32'sh00010000, -32'sh00018000,
                                32'sh7fffffff, 0, 0, 0, 32'sh00008000));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_SCALE, 32'sh80000000, 32'sh7fffffff, 3,
                                0, 0, 0, 32'sh80000000));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_DIV, 32'sh00030000, -32'sh00030000, 7,
                                0, 0, 0, 32'sh00020000));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_DIV, 5, -5, 0, 0, 0, 0, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_DIV, 32'sh80000000, 32'sh7fffffff, 1,
                                0, 0, 0, -1));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_DOT, 32'sh00010000, 32'sh00020000,
                                32'sh00030000, 32'sh00040000, -32'sh00050000,
                                32'sh00060000, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_DOT, 32'sh80000000, 32'sh80000000,
                                32'sh80000000, 32'sh80000000, 32'sh80000000,
                                32'sh80000000, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_CROSS, 32'sh00010000, 0, 0, 0,
                                32'sh00010000, 0, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_CROSS, 32'sh7fffffff, 32'sh80000000,
                                32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                                32'sh80000000, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_NEG, 32'sh80000000, 32'sh7fffffff, 0,
                                0, 0, 0, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_MAG, 32'sh00030000, 32'sh00040000, 0,
                                0, 0, 0, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_MAG, 32'sh80000000, 32'sh80000000,
                                32'sh80000000, 0, 0, 0, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_NORM, 32'sh00030000, -32'sh00040000, 0,
                                0, 0, 0, 0));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_NORM, 0, 0, 0, 1, 2, 3, 4));
    pending_ops.push_back(mk_op(vfa_pkg::CMD_NORM, 1, 0, 0, 0, 0, 0, 0));
    pending_ops.push_back(mk_op(4'd9, 1, 2, 3, 4, 5, 6, 7));
    pending_ops.push_back(mk_op(4'd15, -1, -1, -1, -1, -1, -1, -1));
    wait (pending_ops.size() == 0);

    // sender waits for the pipeline to drain completely
    hold_send = 1'b1;
    wait (expected_results.size() == 0);
    hold_send = 1'b0;

    send_idle_pct = 26; recv_idle_pct = 58;
    repeat (550) pending_ops.push_back(rand_op());
    wait (pending_ops.size() == 0);
    send_idle_pct = 58; recv_idle_pct = 26;
    repeat (550) pending_ops.push_back(rand_op());
    wait (pending_ops.size() == 0);
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (550) pending_ops.push_back(rand_op());
    wait (pending_ops.size() == 0);

    wait (expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (failed || expected_results.size() != 0) begin
      $display("== FAIL ==");
    end else begin
      $display("== PASS ==");
    end
    $finish;
  end

endmodule
